FILE: hdl/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types, codes and the fixed port-to-class map of the port class
// traffic accumulator.
// ----------------------------------------------------------------------------
package pca_pkg;

	localparam int unsigned CLASS_W = 3;
	localparam int unsigned BYTE_W  = 64;
	localparam int unsigned PKT_W   = 32;
	localparam int unsigned DIV_W   = 16;
	localparam int unsigned STEP_W  = 7;

	// Application classes
	localparam logic [CLASS_W-1:0] CLS_WEB     = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_NET     = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_MAIL    = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_SHARE   = 3'd5;
	localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 3'd6;

	// Record kinds
	localparam logic [1:0] KIND_PLAIN   = 2'd0;
	localparam logic [1:0] KIND_FLOW    = 2'd1;
	localparam logic [1:0] KIND_SAMPLED = 2'd2;

	// Operations
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// Divider command
	typedef struct packed {
		logic                start;
		logic [STEP_W-1:0]   steps;
		logic [BYTE_W-1:0]   dividend;
		logic [DIV_W-1:0]    divisor;
	} div_cmd_t;

	// Divider status
	typedef struct packed {
		logic                done;
		logic [BYTE_W-1:0]   quotient;
	} div_sts_t;

	// Map one TCP port to its class
	function automatic logic [CLASS_W-1:0] port_class(input logic [15:0] p);
		logic [CLASS_W-1:0] c;
		c = CLS_UNKNOWN;
		case (p) inside
			16'd80, 16'd443, 16'd8080, 16'd3128, 16'd3130, 16'd9090:
				c = CLS_WEB;
			[16'd20:16'd23], 16'd53, 16'd123, 16'd135, [16'd137:16'd139],
			16'd161, 16'd162, 16'd311, 16'd387, 16'd445, 16'd548, 16'd568,
			16'd569, 16'd873, 16'd989, 16'd990, 16'd992, 16'd1110, 16'd1512,
			16'd2049:
				c = CLS_NET;
			16'd25, 16'd109, 16'd110, 16'd119, 16'd143, 16'd220, 16'd465,
			16'd563, 16'd993, 16'd995:
				c = CLS_MAIL;
			[16'd4000:16'd4999], 16'd412, 16'd1214, 16'd5000, 16'd5500,
			16'd5501, 16'd5555, 16'd6346, 16'd6574, 16'd6666, 16'd6688,
			16'd6697, 16'd6699, 16'd7070, 16'd7777, 16'd8311:
				c = CLS_SHARE;
			default: c = CLS_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/port_class_traffic_accumulator.sv
// ----------------------------------------------------------------------------
// port_class_traffic_accumulator
// Classifies TCP records by port, accumulates per-class bytes and packets,
// and on flush emits per-class rates over the measurement interval.
// ----------------------------------------------------------------------------
// A record is accepted, then makes three passes through one shared
// 32x32 multiplier (low byte word, high byte word, packets) with the
// counter update on the last pass. A flush runs, for each class, 64 + 32
// steps of the one-bit-per-cycle divider and then waits for the output.
// Reset marks all counters invalid so they read as zero, closes the
// interval and sets the interval length register to 1.
module port_class_traffic_accumulator #(
	parameter int unsigned NUM_CLASSES = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// sport[15:0], dport[31:16], byte_count[95:32], pkt_count[127:96],
	// sampling[159:128], time_sec[191:160]
	input  logic [191:0] s_axis_tdata,
	// op[0], record_kind[2:1], is_tcp[3], first_of_flow[4]
	input  logic [4:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// interval_start[31:0], byte_rate[95:32], pkt_rate[127:96]
	output logic [127:0] m_axis_tdata,
	// app_class[2:0]
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	localparam int unsigned KW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_MUL0 = 8'b00000010,
		ST_MUL1 = 8'b00000100,
		ST_MUL2 = 8'b00001000,
		ST_LOAD = 8'b00010000,
		ST_DIVB = 8'b00100000,
		ST_DIVP = 8'b01000000,
		ST_OUT  = 8'b10000000
	} state_t;

	state_t                     st_q;
	logic [15:0]                isec_q;
	logic                       open_q;
	logic [31:0]                first_q;
	logic [NUM_CLASSES-1:0]     vld_q;
	logic [63:0]                byte_tot_q [NUM_CLASSES];
	logic [31:0]                pkt_tot_q  [NUM_CLASSES];
	logic [KW-1:0]              cls_q;
	logic [KW-1:0]              k_q;
	logic [63:0]                bytes_q;
	logic [31:0]                mult_q;
	logic [31:0]                pa_q;
	logic [63:0]                acc_q;
	logic [15:0]                dsr_q;
	logic [63:0]                qb_q;
	logic [63:0]                ob_q;
	logic [31:0]                op_q;
	logic [2:0]                 oc_q;
	logic                       ol_q;

	logic                       in_op, in_tcp, in_first;
	logic [1:0]                 in_kind;
	logic [15:0]                in_sp, in_dp;
	logic [63:0]                in_bytes;
	logic [31:0]                in_pkts, in_samp, in_tsec;
	logic                       acc_rec, drop;
	logic [2:0]                 ca, cb, cmin;
	logic [KW-1:0]              cfold;
	logic [KW-1:0]              ridx;
	logic [63:0]                rd_byte;
	logic [31:0]                rd_pkt;
	logic [31:0]                mul_a;
	logic [63:0]                prod;
	logic                       last_k;
	pca_pkg::div_cmd_t          dcmd;
	pca_pkg::div_sts_t          dsts;

	// Unpack input transfer
	always_comb begin
		in_op    = s_axis_tuser[0];
		in_kind  = s_axis_tuser[2:1];
		in_tcp   = s_axis_tuser[3];
		in_first = s_axis_tuser[4];
		in_sp    = s_axis_tdata[15:0];
		in_dp    = s_axis_tdata[31:16];
		in_bytes = s_axis_tdata[95:32];
		in_pkts  = s_axis_tdata[127:96];
		in_samp  = s_axis_tdata[159:128];
		in_tsec  = s_axis_tdata[191:160];
	end

	assign s_axis_tready = (st_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign acc_rec       = s_axis_tvalid && s_axis_tready;
	assign drop          = !in_tcp || (in_kind == pca_pkg::KIND_FLOW && !in_first);

	// Classify: lower of the two port classes, folded into range
	always_comb begin
		ca    = pca_pkg::port_class(in_sp);
		cb    = pca_pkg::port_class(in_dp);
		cmin  = (ca < cb) ? ca : cb;
		cfold = (5'(cmin) >= 5'(NUM_CLASSES)) ? KW'(NUM_CLASSES - 1) : KW'(cmin);
	end

	// Counter read port; entries not valid read as zero
	always_comb begin
		ridx    = (st_q == ST_MUL2) ? cls_q : k_q;
		rd_byte = vld_q[ridx] ? byte_tot_q[ridx] : 64'd0;
		rd_pkt  = vld_q[ridx] ? pkt_tot_q[ridx] : 32'd0;
	end

	// Shared multiplier
	always_comb begin
		case (st_q)
			ST_MUL0: mul_a = bytes_q[31:0];
			ST_MUL1: mul_a = bytes_q[63:32];
			default: mul_a = pa_q;
		endcase
		prod = {32'd0, mul_a} * {32'd0, mult_q};
	end

	assign last_k = (k_q == KW'(NUM_CLASSES - 1));

	// Divider commands
	always_comb begin
		dcmd.start    = 1'b0;
		dcmd.steps    = pca_pkg::STEP_W'(64);
		dcmd.dividend = rd_byte;
		dcmd.divisor  = dsr_q;
		if (st_q == ST_LOAD) begin
			dcmd.start = 1'b1;
		end else if (st_q == ST_DIVB && dsts.done) begin
			dcmd.start    = 1'b1;
			dcmd.steps    = pca_pkg::STEP_W'(32);
			dcmd.dividend = {rd_pkt, 32'd0};
		end
	end

	pca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.sts    (dsts)
	);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			isec_q <= 16'd1;
			open_q <= 1'b0;
			vld_q  <= '0;
			k_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				isec_q <= cfg_data;
			end
			case (st_q)
				ST_IDLE: begin
					if (acc_rec) begin
						if (in_op == pca_pkg::OP_FLUSH) begin
							if (open_q) begin
								k_q  <= '0;
								st_q <= ST_LOAD;
							end
						end else if (!drop) begin
							if (!open_q) begin
								open_q <= 1'b1;
								vld_q  <= '0;
							end
							st_q <= ST_MUL0;
						end
					end
				end
				ST_MUL0: st_q <= ST_MUL1;
				ST_MUL1: st_q <= ST_MUL2;
				ST_MUL2: begin
					vld_q[cls_q] <= 1'b1;
					st_q         <= ST_IDLE;
				end
				ST_LOAD: st_q <= ST_DIVB;
				ST_DIVB: begin
					if (dsts.done) begin
						st_q <= ST_DIVP;
					end
				end
				ST_DIVP: begin
					if (dsts.done) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						if (last_k) begin
							open_q <= 1'b0;
							st_q   <= ST_IDLE;
						end else begin
							k_q  <= k_q + KW'(1);
							st_q <= ST_LOAD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (acc_rec) begin
					dsr_q   <= (isec_q == 16'd0) ? 16'd1 : isec_q;
					cls_q   <= cfold;
					bytes_q <= in_bytes;
					if (!open_q) begin
						first_q <= in_tsec;
					end
					case (in_kind)
						pca_pkg::KIND_FLOW: begin
							mult_q <= {16'd0, in_samp[15:0]};
							pa_q   <= in_pkts;
						end
						pca_pkg::KIND_SAMPLED: begin
							mult_q <= in_samp;
							pa_q   <= 32'd1;
						end
						default: begin
							mult_q <= 32'd1;
							pa_q   <= 32'd1;
						end
					endcase
				end
			end
			ST_MUL0: acc_q <= prod;
			ST_MUL1: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			ST_MUL2: begin
				byte_tot_q[cls_q] <= rd_byte + acc_q;
				pkt_tot_q[cls_q]  <= rd_pkt + prod[31:0];
			end
			ST_DIVB: begin
				if (dsts.done) begin
					qb_q <= dsts.quotient;
				end
			end
			ST_DIVP: begin
				if (dsts.done) begin
					ob_q <= qb_q;
					op_q <= dsts.quotient[31:0];
					oc_q <= 3'(k_q);
					ol_q <= last_k;
				end
			end
			default: ;
		endcase
	end

	// Output transfer
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata  = {op_q, ob_q, first_q};
	assign m_axis_tuser  = oc_q;
	assign m_axis_tlast  = ol_q;

endmodule

FILE: hdl/pca_div.sv
// ----------------------------------------------------------------------------
// pca_div
// Restoring divider, one quotient bit per cycle. The dividend is taken
// from the top bits of a 64-bit word; after N steps the quotient sits in
// the low N bits.
// ----------------------------------------------------------------------------
module pca_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pca_pkg::div_cmd_t cmd,
	output pca_pkg::div_sts_t sts
);

	logic [pca_pkg::BYTE_W-1:0] dvd_q;
	logic [pca_pkg::DIV_W:0]    rem_q;
	logic [pca_pkg::DIV_W-1:0]  dsr_q;
	logic [pca_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [pca_pkg::DIV_W:0]    rem_sh;
	logic                       ge;

	// Shift in next dividend bit and compare
	always_comb begin
		rem_sh = {rem_q[pca_pkg::DIV_W-1:0], dvd_q[pca_pkg::BYTE_W-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - pca_pkg::STEP_W'(1);
				if (cnt_q == pca_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			dsr_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
			dvd_q <= {dvd_q[pca_pkg::BYTE_W-2:0], ge};
		end
	end

	assign sts.done     = done_q;
	assign sts.quotient = dvd_q;

endmodule
